FILE: sv/pidc_pkg.sv
// shared constants, types and saturation helpers of the clamped-term pid controller
// no dependencies
package pidc_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned DtW   = 24;
	localparam int unsigned ProdW = 2 * DataW;
	localparam int unsigned QuoW  = DataW + DtW;

	// function codes carried in tuser
	localparam logic [1:0] FUNC_UPDATE     = 2'd0;
	localparam logic [1:0] FUNC_RESET_ALL  = 2'd1;
	localparam logic [1:0] FUNC_RESET_INTEG = 2'd2;
	localparam logic [1:0] FUNC_RESET_DERIV = 2'd3;

	// register indexes
	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [2:0] REG_OUT_MIN    = 3'd3;
	localparam logic [2:0] REG_OUT_MAX    = 3'd4;
	localparam logic [2:0] REG_INTEG_MIN  = 3'd5;
	localparam logic [2:0] REG_INTEG_MAX  = 3'd6;
	localparam logic [2:0] REG_HOLD       = 3'd7;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef struct packed {
		logic              start;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [63:0] prod;
	} mul_rsp_t;

	// saturate a 49-bit signed value to the 32-bit range
	function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v > 49'sd2147483647) begin
			r = S32_MAX;
		end else if (v < -49'sd2147483648) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// inverted limits: a value below the lower limit gives the lower limit, any other the upper
	function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		logic signed [31:0] r;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: sv/pidc_mul.sv
// bit-serial signed 32x32 multiplier, one multiplier bit per cycle
// depends on pidc_pkg
module pidc_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  pidc_pkg::mul_req_t req,
	output pidc_pkg::mul_rsp_t rsp
);

	logic signed [31:0] a_q;
	logic [31:0]        b_q;
	logic [31:0]        hi_q;
	logic [31:0]        lo_q;
	logic [4:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic signed [32:0] addend;
	logic signed [32:0] sum;

	always_comb begin
		if (!b_q[0]) begin
			addend = 33'sd0;
		end else if (cnt_q == 5'd31) begin
			addend = -{a_q[31], a_q};
		end else begin
			addend = {a_q[31], a_q};
		end
		sum = $signed({hi_q[31], hi_q}) + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= req.a;
			b_q  <= req.b;
			hi_q <= 32'd0;
			lo_q <= 32'd0;
		end else if (busy_q) begin
			hi_q <= sum[32:1];
			lo_q <= {sum[0], lo_q[31:1]};
			b_q  <= {1'b0, b_q[31:1]};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = $signed({hi_q, lo_q});

endmodule

FILE: sv/pidc_div.sv
// restoring bit-serial divider: (mag * 2^24) / divisor, one quotient bit per cycle
// depends on pidc_pkg
module pidc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] mag,
	input  logic [23:0] divisor,
	output logic        busy,
	output logic [55:0] quo
);

	logic [55:0] n_q;
	logic [23:0] rem_q;
	logic [23:0] dv_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [24:0] trial;
	logic        fits;

	always_comb begin
		trial = {rem_q, n_q[55]};
		fits  = trial >= {1'b0, dv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(pidc_pkg::QuoW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {mag, 24'd0};
			rem_q <= 24'd0;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 24'(trial - {1'b0, dv_q}) : trial[23:0];
			n_q   <= {n_q[54:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = n_q;

endmodule

FILE: sv/pid_controller_clamped_terms.sv
// top level of the clamped-term pid controller with derivative on measurement
// depends on pidc_pkg, pidc_mul, pidc_div
//
// usage:
//   input beats on s_* carry one update or a reset function (tuser); configuration
//   is written through cfg_we / cfg_index / cfg_data, by the user only while the
//   block is idle, which the block does not enforce; an update yields one beat on
//   m_*: control_out, p_term, i_term, d_term; reset functions (all, integral,
//   derivative history) give no beat
//   every product goes through one bit-serial multiplier; the quotient of the
//   derivative uses a bit-serial divider that runs beside the derivative gain
//   product, and the derivative product waits for both; an update always runs
//   the proportional products, the integral ones unless the integral gain is zero
//   or the integral is held, and the derivative ones unless kd is zero
// reset:
//   arst_n clears state, gains to zero and limits to the full 32-bit range
// stall:
//   the result waits in an output register; a new input beat is taken while
//   it waits, and the next result holds in the sum step until m_tready
module pid_controller_clamped_terms (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// measurement, setpoint, time_step, prop_scale, integ_scale, deriv_scale
	input  logic [183:0] s_tdata,
	// func
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// control_out, p_term, i_term, d_term
	output logic [127:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// sequencer steps
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_GP   = 4'd1;
	localparam logic [3:0] S_P    = 4'd2;
	localparam logic [3:0] S_GI   = 4'd3;
	localparam logic [3:0] S_R    = 4'd4;
	localparam logic [3:0] S_INC  = 4'd5;
	localparam logic [3:0] S_DCHK = 4'd6;
	localparam logic [3:0] S_GD   = 4'd7;
	localparam logic [3:0] S_RAW  = 4'd8;
	localparam logic [3:0] S_D    = 4'd9;
	localparam logic [3:0] S_SUM  = 4'd10;

	logic [3:0] state_q;

	// configuration registers
	logic signed [31:0] kp_q, ki_q, kd_q, omin_q, omax_q, imin_q, imax_q;
	logic               hold_q;

	// latched item
	logic signed [31:0] meas_q, is_q, ds_q;
	logic [23:0]        dt_q;

	// working values and state
	logic signed [31:0] e_q, gain_q, p_q, d_q, integ_q, prev_q;
	logic               dm_neg_q;
	logic [127:0]       out_q;
	logic               out_valid_q;

	// multiplier request
	pidc_pkg::mul_req_t mreq_q;
	pidc_pkg::mul_rsp_t mrsp;

	logic        div_start_q;
	logic [31:0] div_mag_q;
	logic        div_busy;
	logic [55:0] div_quo;

	logic signed [31:0] q16, q24, negq16, e_new, dm, raw, integ_sum, total;
	logic signed [33:0] sum3;

	pidc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq_q),
		.rsp    (mrsp)
	);

	pidc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.mag     (div_mag_q),
		.divisor (dt_q),
		.busy    (div_busy),
		.quo     (div_quo)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_comb begin
		// floor shifts of the product, saturated
		q16    = pidc_pkg::sat49({mrsp.prod[63], mrsp.prod[63:16]});
		q24    = pidc_pkg::sat49({{9{mrsp.prod[63]}}, mrsp.prod[63:24]});
		negq16 = pidc_pkg::sat49(-{mrsp.prod[63], mrsp.prod[63:16]});
		e_new  = pidc_pkg::sat49(
			{{17{s_tdata[63]}}, s_tdata[63:32]} - {{17{s_tdata[31]}}, s_tdata[31:0]});
		dm     = pidc_pkg::sat49({{17{meas_q[31]}}, meas_q} - {{17{prev_q[31]}}, prev_q});
		// signed, truncated quotient, saturated
		if (dt_q == 24'd0) begin
			raw = 32'sd0;
		end else if (!dm_neg_q) begin
			raw = (div_quo > 56'h7fffffff) ? pidc_pkg::S32_MAX : div_quo[31:0];
		end else begin
			raw = (div_quo > 56'h80000000) ? pidc_pkg::S32_MIN : 32'(-div_quo[31:0]);
		end
		integ_sum = pidc_pkg::sat49({{17{integ_q[31]}}, integ_q} + {{17{q24[31]}}, q24});
		sum3 = {{2{p_q[31]}}, p_q} + {{2{integ_q[31]}}, integ_q} + {{2{d_q[31]}}, d_q};
		total = pidc_pkg::clamp32(pidc_pkg::sat49({{15{sum3[33]}}, sum3}), omin_q, omax_q);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= 32'sd0;
			ki_q   <= 32'sd0;
			kd_q   <= 32'sd0;
			omin_q <= pidc_pkg::S32_MIN;
			omax_q <= pidc_pkg::S32_MAX;
			imin_q <= pidc_pkg::S32_MIN;
			imax_q <= pidc_pkg::S32_MAX;
			hold_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pidc_pkg::REG_PROP_GAIN:  kp_q   <= cfg_data;
				pidc_pkg::REG_INTEG_GAIN: ki_q   <= cfg_data;
				pidc_pkg::REG_DERIV_GAIN: kd_q   <= cfg_data;
				pidc_pkg::REG_OUT_MIN:    omin_q <= cfg_data;
				pidc_pkg::REG_OUT_MAX:    omax_q <= cfg_data;
				pidc_pkg::REG_INTEG_MIN:  imin_q <= cfg_data;
				pidc_pkg::REG_INTEG_MAX:  imax_q <= cfg_data;
				pidc_pkg::REG_HOLD:       hold_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			integ_q      <= 32'sd0;
			prev_q       <= 32'sd0;
			out_valid_q  <= 1'b0;
			mreq_q.start <= 1'b0;
			mreq_q.a     <= 32'sd0;
			mreq_q.b     <= 32'sd0;
			div_start_q  <= 1'b0;
		end else begin
			mreq_q.start <= 1'b0;
			div_start_q  <= 1'b0;
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						case (s_tuser)
							pidc_pkg::FUNC_RESET_ALL: begin
								integ_q <= 32'sd0;
								prev_q  <= 32'sd0;
							end
							pidc_pkg::FUNC_RESET_INTEG: integ_q <= 32'sd0;
							pidc_pkg::FUNC_RESET_DERIV: prev_q  <= 32'sd0;
							default: begin
								// update: error now, then the proportional gain product
								mreq_q.start <= 1'b1;
								mreq_q.a     <= kp_q;
								mreq_q.b     <= s_tdata[119:88];
								state_q      <= S_GP;
							end
						endcase
					end
				end
				S_GP: begin
					if (mrsp.done) begin
						mreq_q.start <= 1'b1;
						mreq_q.a     <= q16;
						mreq_q.b     <= e_q;
						state_q      <= S_P;
					end
				end
				S_P: begin
					if (mrsp.done) begin
						if (ki_q == 32'sd0) begin
							integ_q <= 32'sd0;
							state_q <= S_DCHK;
						end else if (hold_q) begin
							state_q <= S_DCHK;
						end else begin
							mreq_q.start <= 1'b1;
							mreq_q.a     <= ki_q;
							mreq_q.b     <= is_q;
							state_q      <= S_GI;
						end
					end
				end
				S_GI: begin
					if (mrsp.done) begin
						mreq_q.start <= 1'b1;
						mreq_q.a     <= e_q;
						mreq_q.b     <= q16;
						state_q      <= S_R;
					end
				end
				S_R: begin
					if (mrsp.done) begin
						// time step is unsigned, so it enters as a positive operand
						mreq_q.start <= 1'b1;
						mreq_q.a     <= q16;
						mreq_q.b     <= {8'd0, dt_q};
						state_q      <= S_INC;
					end
				end
				S_INC: begin
					if (mrsp.done) begin
						integ_q <= pidc_pkg::clamp32(integ_sum, imin_q, imax_q);
						state_q <= S_DCHK;
					end
				end
				S_DCHK: begin
					if (kd_q == 32'sd0) begin
						state_q <= S_SUM;
					end else begin
						prev_q       <= meas_q;
						mreq_q.start <= 1'b1;
						mreq_q.a     <= kd_q;
						mreq_q.b     <= ds_q;
						div_start_q  <= (dt_q != 24'd0);
						state_q      <= S_GD;
					end
				end
				S_GD: begin
					if (mrsp.done) begin
						state_q <= S_RAW;
					end
				end
				S_RAW: begin
					if (!div_busy && !div_start_q) begin
						mreq_q.start <= 1'b1;
						mreq_q.a     <= gain_q;
						mreq_q.b     <= raw;
						state_q      <= S_D;
					end
				end
				S_D: begin
					if (mrsp.done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid && s_tuser == pidc_pkg::FUNC_UPDATE) begin
			meas_q <= s_tdata[31:0];
			dt_q   <= s_tdata[87:64];
			is_q   <= s_tdata[151:120];
			ds_q   <= s_tdata[183:152];
			e_q    <= e_new;
			d_q    <= 32'sd0;
		end
		if (state_q == S_P && mrsp.done) begin
			p_q <= pidc_pkg::clamp32(q16, omin_q, omax_q);
		end
		if (state_q == S_GD && mrsp.done) begin
			gain_q <= q16;
		end
		if (state_q == S_DCHK) begin
			dm_neg_q  <= dm[31];
			div_mag_q <= dm[31] ? 32'(-dm) : dm;
		end
		if (state_q == S_D && mrsp.done) begin
			d_q <= pidc_pkg::clamp32(negq16, omin_q, omax_q);
		end
		if (state_q == S_SUM && (!out_valid_q || m_tready)) begin
			out_q <= {d_q, integ_q, p_q, total};
		end
	end

	// the multiplier runs only while an update is in progress
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mrsp.busy)
		else $error("multiplier busy while idle");

	// a new result appears only out of the sum step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == S_SUM))
		else $error("result raised outside sum step");

	// the quotient is consumed only after the divider has finished
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_D) |-> !div_busy)
		else $error("derivative product started before quotient");

endmodule

FILE: tb/sv/tb_top.sv
// self-checking bench for the clamped-term pid controller: directed and random beats,
// an in-bench fixed-point predictor and a scoreboard class; depends on pidc_pkg and the top

class pid_scoreboard;
	logic [127:0] pending[$];
	int errors;
	int checked;

	// gains, limits and loop state mirrored from the block
	logic signed [31:0] kp, ki, kd, omin, omax, imin, imax;
	logic hold;
	logic signed [31:0] prev_meas, integ;

	function new();
		errors = 0;
		checked = 0;
		kp = 32'sd0;
		ki = 32'sd0;
		kd = 32'sd0;
		omin = pidc_pkg::S32_MIN;
		omax = pidc_pkg::S32_MAX;
		imin = pidc_pkg::S32_MIN;
		imax = pidc_pkg::S32_MAX;
		hold = 1'b0;
		prev_meas = 32'sd0;
		integ = 32'sd0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] v);
		case (idx)
			pidc_pkg::REG_PROP_GAIN: kp = v;
			pidc_pkg::REG_INTEG_GAIN: ki = v;
			pidc_pkg::REG_DERIV_GAIN: kd = v;
			pidc_pkg::REG_OUT_MIN: omin = v;
			pidc_pkg::REG_OUT_MAX: omax = v;
			pidc_pkg::REG_INTEG_MIN: imin = v;
			pidc_pkg::REG_INTEG_MAX: imax = v;
			default: hold = v[0];
		endcase
	endfunction

	function logic signed [31:0] sat(longint v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = pidc_pkg::S32_MAX;
		else if (v < -64'sd2147483648) r = pidc_pkg::S32_MIN;
		else r = v[31:0];
		return r;
	endfunction

	function logic signed [31:0] lim(logic signed [31:0] v, logic signed [31:0] lo,
			logic signed [31:0] hi);
		logic signed [31:0] r;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	// q16.16 product, arithmetic shift floors
	function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return sat(p >>> 16);
	endfunction

	// note an accepted input beat and queue its result if it has one
	function void note_input(logic [1:0] fn, logic [183:0] d);
		logic signed [31:0] meas, sp, e, p, dv, tot, gi, r, gd, dm, raw;
		longint dt, q;
		meas = d[31:0];
		sp = d[63:32];
		dt = longint'({40'd0, d[87:64]});
		case (fn)
			pidc_pkg::FUNC_RESET_ALL: begin
				prev_meas = 32'sd0;
				integ = 32'sd0;
			end
			pidc_pkg::FUNC_RESET_INTEG: integ = 32'sd0;
			pidc_pkg::FUNC_RESET_DERIV: prev_meas = 32'sd0;
			default: begin
				e = sat(longint'(sp) - longint'(meas));
				p = lim(qmul(qmul(kp, d[119:88]), e), omin, omax);
				if (ki == 0) begin
					integ = 32'sd0;
				end else if (!hold) begin
					gi = qmul(ki, d[151:120]);
					r = qmul(e, gi);
					integ = lim(sat(longint'(integ) + (sat((longint'(r) * dt) >>> 24))),
						imin, imax);
				end
				dv = 32'sd0;
				if (kd != 0) begin
					dm = sat(longint'(meas) - longint'(prev_meas));
					gd = qmul(kd, d[183:152]);
					raw = 32'sd0;
					if (dt != 0) begin
						q = (longint'(dm) * 64'sd16777216) / dt;
						raw = sat(q);
					end
					q = (longint'(gd) * longint'(raw)) >>> 16;
					dv = lim(sat(-q), omin, omax);
					prev_meas = meas;
				end
				tot = lim(sat(longint'(p) + longint'(integ) + longint'(dv)), omin, omax);
				pending.push_back({dv, integ, p, tot});
			end
		endcase
	endfunction

	function void check_result(logic [127:0] got);
		logic [127:0] want;
		if (pending.size() == 0) begin
			$error("result beat with nothing expected: %h", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		checked++;
		if (got[31:0] !== want[31:0]) begin
			$error("control_out exp %0d got %0d", $signed(want[31:0]), $signed(got[31:0]));
			errors++;
		end
		if (got[63:32] !== want[63:32]) begin
			$error("p_term exp %0d got %0d", $signed(want[63:32]), $signed(got[63:32]));
			errors++;
		end
		if (got[95:64] !== want[95:64]) begin
			$error("i_term exp %0d got %0d", $signed(want[95:64]), $signed(got[95:64]));
			errors++;
		end
		if (got[127:96] !== want[127:96]) begin
			$error("d_term exp %0d got %0d", $signed(want[127:96]), $signed(got[127:96]));
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [183:0] s_tdata;
	logic [1:0] s_tuser;
	logic [127:0] m_tdata;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	pid_scoreboard sb;
	int cycles;
	int beats_sent;
	int resets_sent;
	bit calm;          // long stretch with no idling on either side
	bit drain_done;

	localparam int CycleLimit = 2000000;
	localparam int SettleCycles = 250;

	pid_controller_clamped_terms uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = pidc_pkg::FUNC_UPDATE;
		m_tready = 0;
		cfg_we = 0;
		cfg_index = pidc_pkg::REG_PROP_GAIN;
		cfg_data = '0;
		calm = 0;
		drain_done = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// result side: random stalls, checks on every accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			m_tready <= calm || drain_done || ($urandom_range(99) >= 21);
		end
	end

	// one input beat, with random idle before it; held until accepted
	// tvalid stays up after the beat so the next one can follow without a gap
	task automatic send(logic [1:0] fn, logic [183:0] d);
		cfg_we <= 0;
		if (!calm && $urandom_range(99) < 21) begin
			s_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < 21) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= fn;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(fn, d);
		beats_sent++;
		if (fn != pidc_pkg::FUNC_UPDATE) resets_sent++;
	endtask

	// wait for every expected beat, then let the block settle
	task automatic drain();
		s_tvalid <= 0;
		cfg_we <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	function automatic logic [31:0] rnd32();
		logic [31:0] v;
		case ($urandom_range(5))
			0: v = pidc_pkg::S32_MAX;
			1: v = pidc_pkg::S32_MIN;
			2: v = $urandom_range(131072) - 65536;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// update beat: measurement, setpoint, time_step, three scales
	function automatic logic [183:0] upd(logic [31:0] m, logic [31:0] sp, logic [23:0] dt,
			logic [31:0] ps, logic [31:0] is, logic [31:0] ds);
		return {ds, is, ps, dt, sp, m};
	endfunction

	function automatic logic [23:0] rnd_dt();
		logic [23:0] v;
		case ($urandom_range(4))
			0: v = 24'd0;
			1: v = 24'hffffff;
			2: v = 24'($urandom_range(4096, 1));
			default: v = 24'($urandom);
		endcase
		return v;
	endfunction

	task automatic random_gains();
		int k;
		for (k = 0; k < 8; k++) begin
			if (k == pidc_pkg::REG_HOLD)
				cfg_write(pidc_pkg::REG_HOLD, {31'd0, ($urandom_range(3) == 0)});
			else if (k == pidc_pkg::REG_PROP_GAIN || k == pidc_pkg::REG_INTEG_GAIN ||
					k == pidc_pkg::REG_DERIV_GAIN)
				cfg_write(k[2:0], ($urandom_range(5) == 0) ? 32'd0 : rnd32());
			else cfg_write(k[2:0], rnd32());
		end
		// mostly sane limits so the terms are not pinned
		if ($urandom_range(3) != 0) begin
			cfg_write(pidc_pkg::REG_OUT_MIN, -$urandom_range(32'h7fffffff));
			cfg_write(pidc_pkg::REG_OUT_MAX, $urandom_range(32'h7fffffff));
			cfg_write(pidc_pkg::REG_INTEG_MIN, -$urandom_range(32'h7fffffff));
			cfg_write(pidc_pkg::REG_INTEG_MAX, $urandom_range(32'h7fffffff));
		end
	endtask

	initial begin : stim
		int i, ph;
		logic [31:0] m;
		beats_sent = 0;
		resets_sent = 0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: gains at unity first, then extremes
		cfg_write(pidc_pkg::REG_PROP_GAIN, 32'h00010000);
		cfg_write(pidc_pkg::REG_INTEG_GAIN, 32'h00010000);
		cfg_write(pidc_pkg::REG_DERIV_GAIN, 32'h00010000);
		send(pidc_pkg::FUNC_UPDATE, upd(32'h00010000, 32'h00030000, 24'h100000,
			32'h00010000, 32'h00010000, 32'h00010000));
		send(pidc_pkg::FUNC_UPDATE, upd(pidc_pkg::S32_MAX, pidc_pkg::S32_MIN, 24'hffffff,
			pidc_pkg::S32_MAX, pidc_pkg::S32_MAX, pidc_pkg::S32_MAX));
		send(pidc_pkg::FUNC_UPDATE, upd(pidc_pkg::S32_MIN, pidc_pkg::S32_MAX, 24'd1,
			pidc_pkg::S32_MIN, pidc_pkg::S32_MIN, pidc_pkg::S32_MIN));
		// zero time step: no derivative, integral still
		send(pidc_pkg::FUNC_UPDATE,
			upd(32'h12345678, 32'h0, 24'd0, 32'h10000, 32'h10000, 32'h10000));
		send(pidc_pkg::FUNC_RESET_DERIV, '0);
		send(pidc_pkg::FUNC_UPDATE,
			upd(32'hfff00000, 32'h0, 24'd7, 32'h10000, 32'h10000, 32'h10000));
		send(pidc_pkg::FUNC_RESET_INTEG, '1);
		send(pidc_pkg::FUNC_UPDATE,
			upd(32'h0, 32'h00500000, 24'h800000, 32'h10000, 32'h10000, 32'h0));
		send(pidc_pkg::FUNC_RESET_ALL, '0);
		send(pidc_pkg::FUNC_UPDATE,
			upd(32'h7fff0000, 32'h0, 24'h3, 32'hffff0000, 32'h10000, 32'h10000));
		drain();
		// hold the integral, then inverted limits
		cfg_write(pidc_pkg::REG_HOLD, 32'd1);
		send(pidc_pkg::FUNC_UPDATE,
			upd(32'h0, 32'h00400000, 24'h400000, 32'h10000, 32'h10000, 32'h10000));
		drain();
		cfg_write(pidc_pkg::REG_HOLD, 32'd0);
		cfg_write(pidc_pkg::REG_OUT_MIN, 32'h00010000);
		cfg_write(pidc_pkg::REG_OUT_MAX, 32'hffff0000);
		cfg_write(pidc_pkg::REG_INTEG_MIN, 32'h00020000);
		cfg_write(pidc_pkg::REG_INTEG_MAX, 32'hfffe0000);
		send(pidc_pkg::FUNC_UPDATE,
			upd(32'h0, 32'h00400000, 24'h400000, 32'h10000, 32'h10000, 32'h10000));
		send(pidc_pkg::FUNC_UPDATE,
			upd(32'h00900000, 32'h0, 24'h10, 32'h10000, 32'h10000, 32'h10000));
		drain();
		// gains of zero: integral forced to zero, no derivative
		cfg_write(pidc_pkg::REG_INTEG_GAIN, 32'd0);
		cfg_write(pidc_pkg::REG_DERIV_GAIN, 32'd0);
		cfg_write(pidc_pkg::REG_OUT_MIN, pidc_pkg::S32_MIN);
		cfg_write(pidc_pkg::REG_OUT_MAX, pidc_pkg::S32_MAX);
		cfg_write(pidc_pkg::REG_INTEG_MIN, pidc_pkg::S32_MIN);
		cfg_write(pidc_pkg::REG_INTEG_MAX, pidc_pkg::S32_MAX);
		send(pidc_pkg::FUNC_UPDATE,
			upd(32'h00050000, 32'h0, 24'h1000, 32'h10000, 32'h10000, 32'h10000));
		drain();

		// random phases; the third runs without any idling
		for (ph = 0; ph < 12; ph++) begin
			random_gains();
			calm = (ph == 2);
			m = rnd32();
			for (i = 0; i < 150; i++) begin
				// mostly smooth measurement tracks, some jumps and resets
				if ($urandom_range(9) == 0) m = rnd32();
				else m = m + $urandom_range(8192) - 4096;
				if ($urandom_range(15) == 0)
					send(2'($urandom_range(3, 1)), 184'({$urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom}));
				else
					send(pidc_pkg::FUNC_UPDATE, upd(m, ($urandom_range(3) == 0) ? rnd32() :
						m + $urandom_range(65536) - 32768, rnd_dt(), rnd32(), rnd32(),
						rnd32()));
			end
			calm = 0;
			// sender waits for every expected beat before reconfiguring
			drain();
		end
		drain_done = 1;
		drain();
		$display("tb_top: %0d input beats (%0d resets), %0d results checked over 12 gain sets",
			beats_sent, resets_sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
